// ===== sv/lobby_slot_cache_with_expiry_top_macros.svh =====
// ----------------------------------------------------------------------------
// lobby slot cache assertion macros
// implication checks for the cache control logic
// ----------------------------------------------------------------------------
`ifndef LOBBY_SLOT_CACHE_WITH_EXPIRY_TOP_MACROS_SVH
`define LOBBY_SLOT_CACHE_WITH_EXPIRY_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define LSCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsce check failed");
// next-cycle implication
`define LSCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsce check failed");
`else
`define LSCE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LSCE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/lsce_pkg.sv =====
// ----------------------------------------------------------------------------
// lsce_pkg
// shared types and constants of the lobby slot cache
// ----------------------------------------------------------------------------
`default_nettype none

package lsce_pkg;

    localparam int DEFAULT_ENTRIES = 8;
    localparam int TIME_W          = 48;
    localparam int WORD_W          = 64;
    localparam int KEY_W           = 4 * WORD_W;
    localparam int SLOT_W          = 3;
    localparam int CFG_W           = 32;
    localparam int CFG_IDX_W       = 2;

    localparam logic             RST_CACHE_ENABLE    = 1'b1;
    localparam logic [CFG_W-1:0] RST_RESEND_INTERVAL = 32'd57600000;
    localparam logic [CFG_W-1:0] RST_EXPIRY_AGE      = 32'd576000000;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CACHE_ENABLE    = 2'd0,
        CFG_RESEND_INTERVAL = 2'd1,
        CFG_EXPIRY_AGE      = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic             enable;
        logic [CFG_W-1:0] resend_interval;
        logic [CFG_W-1:0] expiry_age;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_TCHECK,
        ST_EXPIRE,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== sv/lsce_ram.sv =====
// ----------------------------------------------------------------------------
// lsce_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module lsce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/lsce_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsce_ctrl
// slot scan, replacement choice, expiry sweep and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "lobby_slot_cache_with_expiry_top_macros.svh"

module lsce_ctrl
    import lsce_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire cfg_t                       cfg,
    // input channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       kind,
    input  wire logic [TIME_W-1:0]          now_tick,
    input  wire logic                       key_present,
    input  wire logic [WORD_W-1:0]          key_word0,
    input  wire logic [WORD_W-1:0]          key_word1,
    input  wire logic [WORD_W-1:0]          key_word2,
    input  wire logic [WORD_W-1:0]          key_word3,
    // result channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic                            result_kind,
    output logic      [SLOT_W-1:0]          slot,
    output logic                            matched_existing,
    output logic                            last,
    // key and stamp rams
    output logic                            wr_en,
    output logic      [$clog2(ENTRIES)-1:0] wr_addr,
    output logic      [KEY_W-1:0]           key_wdata,
    output logic      [TIME_W-1:0]          stamp_wdata,
    output logic      [$clog2(ENTRIES)-1:0] rd_addr,
    input  wire logic [KEY_W-1:0]           key_rdata,
    input  wire logic [TIME_W-1:0]          stamp_rdata
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    state_t              state_reg, state_next;

    logic [TIME_W-1:0]   now_reg, now_next;
    logic                has_key_reg, has_key_next;
    logic [KEY_W-1:0]    key_reg, key_next;

    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [ENTRIES-1:0]  keyed_reg, keyed_next;
    logic [TIME_W-1:0]   last_sweep_reg, last_sweep_next;

    logic [CNT_W-1:0]    iss_reg, iss_next;
    logic                ev_valid_reg, ev_valid_next;
    logic [IDX_W-1:0]    ev_idx_reg, ev_idx_next;

    logic                found_reg, found_next;
    logic [IDX_W-1:0]    chosen_reg, chosen_next;
    logic                matched_reg, matched_next;
    logic [TIME_W-1:0]   oldest_reg, oldest_next;
    logic [IDX_W-1:0]    victim_idx_reg, victim_idx_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic                out_matched_reg, out_matched_next;
    logic                out_last_reg, out_last_next;

    always_comb
    begin
        logic                    out_free;
        logic                    done_scan;
        logic [IDX_W-1:0]        sel_idx;
        logic [IDX_W+SLOT_W-1:0] sel_wide;
        logic [TIME_W-1:0]       diff;
        logic [ENTRIES-1:0]      above;

        state_next       = state_reg;
        now_next         = now_reg;
        has_key_next     = has_key_reg;
        key_next         = key_reg;
        valid_next       = valid_reg;
        keyed_next       = keyed_reg;
        last_sweep_next  = last_sweep_reg;
        iss_next         = iss_reg;
        ev_valid_next    = 1'b0;
        ev_idx_next      = ev_idx_reg;
        found_next       = found_reg;
        chosen_next      = chosen_reg;
        matched_next     = matched_reg;
        oldest_next      = oldest_reg;
        victim_idx_next  = victim_idx_reg;
        out_kind_next    = out_kind_reg;
        out_slot_next    = out_slot_reg;
        out_matched_next = out_matched_reg;
        out_last_next    = out_last_reg;

        out_free       = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg && out_stall;
        done_scan      = 1'b0;
        sel_idx        = found_reg ? chosen_reg : victim_idx_reg;
        diff           = '0;
        above          = '0;

        wr_en   = 1'b0;
        rd_addr = iss_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next     = now_tick;
                    has_key_next = key_present;
                    key_next     = {key_word3, key_word2, key_word1, key_word0};
                    iss_next     = '0;
                    found_next   = 1'b0;
                    matched_next = 1'b0;
                    oldest_next  = '0;
                    victim_idx_next = '0;
                    if (cfg.enable)
                    begin
                        state_next = (kind == KIND_STORE) ? ST_SCAN : ST_TCHECK;
                    end
                end
            end

            ST_SCAN:
            begin
                if (iss_reg != CNT_W'(ENTRIES))
                begin
                    iss_next      = iss_reg + CNT_W'(1);
                    ev_valid_next = 1'b1;
                    ev_idx_next   = iss_reg[IDX_W-1:0];
                end
                if (ev_valid_reg)
                begin
                    if (!valid_reg[ev_idx_reg])
                    begin
                        if (!found_reg)
                        begin
                            found_next  = 1'b1;
                            chosen_next = ev_idx_reg;
                        end
                    end
                    else if (has_key_reg && keyed_reg[ev_idx_reg] && key_rdata == key_reg)
                    begin
                        // first matching identity wins outright
                        found_next   = 1'b1;
                        chosen_next  = ev_idx_reg;
                        matched_next = 1'b1;
                        done_scan    = 1'b1;
                    end
                    else if (oldest_reg == '0 || stamp_rdata < oldest_reg)
                    begin
                        // a zero minimum counts as unset, so the next stamp restarts it
                        oldest_next     = stamp_rdata;
                        victim_idx_next = ev_idx_reg;
                    end
                    if (done_scan || ev_idx_reg == IDX_W'(ENTRIES - 1))
                    begin
                        state_next    = ST_WRITE;
                        ev_valid_next = 1'b0;
                    end
                end
            end

            ST_WRITE:
            begin
                if (out_free)
                begin
                    wr_en                = 1'b1;
                    valid_next[sel_idx]  = 1'b1;
                    keyed_next[sel_idx]  = has_key_reg;
                    out_valid_next       = 1'b1;
                    out_kind_next        = KIND_STORE;
                    out_matched_next     = matched_reg;
                    out_last_next        = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            ST_TCHECK:
            begin
                diff = now_reg - last_sweep_reg;
                if (last_sweep_reg != '0 &&
                    diff < {{(TIME_W - CFG_W){1'b0}}, cfg.resend_interval})
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    last_sweep_next = now_reg;
                    iss_next        = '0;
                    state_next      = ST_EXPIRE;
                end
            end

            ST_EXPIRE:
            begin
                if (iss_reg != CNT_W'(ENTRIES))
                begin
                    iss_next      = iss_reg + CNT_W'(1);
                    ev_valid_next = 1'b1;
                    ev_idx_next   = iss_reg[IDX_W-1:0];
                end
                if (ev_valid_reg)
                begin
                    diff = now_reg - stamp_rdata;
                    if (valid_reg[ev_idx_reg] &&
                        diff > {{(TIME_W - CFG_W){1'b0}}, cfg.expiry_age})
                    begin
                        valid_next[ev_idx_reg] = 1'b0;
                    end
                    if (ev_idx_reg == IDX_W'(ENTRIES - 1))
                    begin
                        // survivors are now exactly the set valid bits
                        state_next    = ST_EMIT;
                        iss_next      = '0;
                        ev_valid_next = 1'b0;
                    end
                end
            end

            ST_EMIT:
            begin
                sel_idx = iss_reg[IDX_W-1:0];
                for (int j = 0; j < ENTRIES; j++)
                begin
                    above[j] = (IDX_W'(j) > sel_idx);
                end
                if (iss_reg == CNT_W'(ENTRIES))
                begin
                    state_next = ST_IDLE;
                end
                else if (!valid_reg[sel_idx])
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                else if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_kind_next    = KIND_TICK;
                    out_matched_next = 1'b0;
                    out_last_next    = !(|(valid_reg & above));
                    iss_next         = iss_reg + CNT_W'(1);
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        sel_wide = {{SLOT_W{1'b0}}, sel_idx};
        if (out_valid_next && out_free)
        begin
            out_slot_next = sel_wide[SLOT_W-1:0];
        end

        wr_addr     = sel_idx;
        key_wdata   = key_reg;
        stamp_wdata = now_reg;
        in_stall    = (state_reg != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            keyed_reg      <= '0;
            last_sweep_reg <= '0;
            iss_reg        <= '0;
            ev_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            keyed_reg      <= keyed_next;
            last_sweep_reg <= last_sweep_next;
            iss_reg        <= iss_next;
            ev_valid_reg   <= ev_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg         <= now_next;
        has_key_reg     <= has_key_next;
        key_reg         <= key_next;
        ev_idx_reg      <= ev_idx_next;
        found_reg       <= found_next;
        chosen_reg      <= chosen_next;
        matched_reg     <= matched_next;
        oldest_reg      <= oldest_next;
        victim_idx_reg  <= victim_idx_next;
        out_kind_reg    <= out_kind_next;
        out_slot_reg    <= out_slot_next;
        out_matched_reg <= out_matched_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid        = out_valid_reg;
    assign result_kind      = out_kind_reg;
    assign slot             = out_slot_reg;
    assign matched_existing = out_matched_reg;
    assign last             = out_last_reg;

    `LSCE_ASSERT_NXT(a_store_sets_valid, clk, rst_n, wr_en, valid_reg[$past(wr_addr)])
    `LSCE_ASSERT_NXT(a_sweep_never_adds, clk, rst_n, state_reg == ST_EXPIRE, (valid_reg & ~$past(valid_reg)) == '0)
    `LSCE_ASSERT_IMP(a_tick_no_match, clk, rst_n, out_valid_reg && out_kind_reg == KIND_TICK, !out_matched_reg)
    `LSCE_ASSERT_IMP(a_store_single, clk, rst_n, out_valid_reg && out_kind_reg == KIND_STORE, out_last_reg)

endmodule

`default_nettype wire

// ===== sv/lobby_slot_cache_with_expiry_top.sv =====
// store item: pipelined scan of the key and stamp rams, one entry per cycle, ending early
// on an identity match, then a write state that waits for the output and loads the result
// tick item: inside the interval it returns to idle; otherwise an expiry pass over the
// stamp ram, then a pass over the slots to list survivors; one item at a time; a disabled
// cache takes items with no stall or result; output stalls hold the write and emit states
// reset clears valid bits, sweep time, control; configuration to defaults; rams undefined
// ----------------------------------------------------------------------------
// lobby_slot_cache_with_expiry_top
// keyed announcement cache with oldest replacement and age expiry
// ----------------------------------------------------------------------------
`default_nettype none

module lobby_slot_cache_with_expiry_top
    import lsce_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    // input channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 kind,
    input  wire logic [TIME_W-1:0]    now_tick,
    input  wire logic                 key_present,
    input  wire logic [WORD_W-1:0]    key_word0,
    input  wire logic [WORD_W-1:0]    key_word1,
    input  wire logic [WORD_W-1:0]    key_word2,
    input  wire logic [WORD_W-1:0]    key_word3,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      result_kind,
    output logic      [SLOT_W-1:0]    slot,
    output logic                      matched_existing,
    output logic                      last
);

    localparam int IDX_W = $clog2(ENTRIES);

    cfg_t              cfg_reg, cfg_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [KEY_W-1:0]  key_wdata;
    logic [TIME_W-1:0] stamp_wdata;
    logic [IDX_W-1:0]  rd_addr;
    logic [KEY_W-1:0]  key_rdata;
    logic [TIME_W-1:0] stamp_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CACHE_ENABLE:    cfg_next.enable          = cfg_data[0];
                CFG_RESEND_INTERVAL: cfg_next.resend_interval = cfg_data;
                CFG_EXPIRY_AGE:      cfg_next.expiry_age      = cfg_data;
                default:             cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable          <= RST_CACHE_ENABLE;
            cfg_reg.resend_interval <= RST_RESEND_INTERVAL;
            cfg_reg.expiry_age      <= RST_EXPIRY_AGE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lsce_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .now_tick         (now_tick),
        .key_present      (key_present),
        .key_word0        (key_word0),
        .key_word1        (key_word1),
        .key_word2        (key_word2),
        .key_word3        (key_word3),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .slot             (slot),
        .matched_existing (matched_existing),
        .last             (last),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .key_wdata        (key_wdata),
        .stamp_wdata      (stamp_wdata),
        .rd_addr          (rd_addr),
        .key_rdata        (key_rdata),
        .stamp_rdata      (stamp_rdata)
    );

    // full 256-bit identity per slot
    lsce_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (key_wdata),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    lsce_ram #(
        .WIDTH (TIME_W),
        .DEPTH (ENTRIES)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (stamp_wdata),
        .raddr (rd_addr),
        .rdata (stamp_rdata)
    );

endmodule

`default_nettype wire

// ===== bench/tb_lobby_slot_cache_with_expiry_top.sv =====
// ----------------------------------------------------------------------------
// tb_lobby_slot_cache_with_expiry_top
// drives store and tick items into the slot cache and predicts every slot
// report from a cycle-free copy of the table, then compares each result in
// order; directed corner items first, then random phases under varied idling
// and output stalls
`default_nettype none

module tb_lobby_slot_cache_with_expiry_top
    import lsce_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES          = DEFAULT_ENTRIES;
    localparam int POOL_SIZE        = 12;
    localparam int RANDOM_PER_PHASE = 48;
    localparam int HOLD_CYCLES      = 400;
    localparam int SETTLE_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT   = 20000;

    typedef struct packed {
        logic                   kind;
        logic [TIME_W-1:0]      now;
        logic                   key_present;
        logic [3:0][WORD_W-1:0] key;
    } cache_item_t;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic              matched;
        logic              last;
    } slot_result_t;

    class slot_cache_scoreboard;
        logic                   enable;
        logic [CFG_W-1:0]       resend_gap;
        logic [CFG_W-1:0]       max_age;
        logic                   live[ENTRIES];
        logic                   keyed[ENTRIES];
        logic [3:0][WORD_W-1:0] ident[ENTRIES];
        logic [TIME_W-1:0]      stamp[ENTRIES];
        logic [TIME_W-1:0]      sweep_at;
        slot_result_t           pending_slots[$];
        int                     errors;

        function new();
            enable     = RST_CACHE_ENABLE;
            resend_gap = RST_RESEND_INTERVAL;
            max_age    = RST_EXPIRY_AGE;
            foreach (live[i])
            begin
                live[i]  = 1'b0;
                keyed[i] = 1'b0;
                ident[i] = '0;
                stamp[i] = '0;
            end
            sweep_at = '0;
            errors   = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_CACHE_ENABLE:    enable = data[0];
                CFG_RESEND_INTERVAL: resend_gap = data;
                CFG_EXPIRY_AGE:      max_age = data;
                default:             ;
            endcase
        endfunction

        function int outstanding();
            return pending_slots.size();
        endfunction

        function void note_item(cache_item_t it);
            int                chosen;
            int                victim;
            logic [TIME_W-1:0] oldest;
            logic [TIME_W-1:0] age;
            logic              hit;
            slot_result_t      r;
            slot_result_t      sweep_q[$];
            if (!enable)
                return;
            if (it.kind == KIND_STORE)
            begin
                chosen = -1;
                victim = 0;
                oldest = '0;
                hit    = 1'b0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!live[i])
                    begin
                        if (chosen < 0)
                            chosen = i;
                    end
                    else if (it.key_present && keyed[i] && ident[i] == it.key)
                    begin
                        chosen = i;
                        hit    = 1'b1;
                        break;
                    end
                    // a zero minimum counts as unset, so the next stamp restarts it
                    else if (oldest == 0 || stamp[i] < oldest)
                    begin
                        oldest = stamp[i];
                        victim = i;
                    end
                end
                if (chosen < 0)
                    chosen = victim;
                ident[chosen] = it.key;
                keyed[chosen] = it.key_present;
                stamp[chosen] = it.now;
                live[chosen]  = 1'b1;
                r.kind    = KIND_STORE;
                r.slot    = chosen[SLOT_W-1:0];
                r.matched = hit;
                r.last    = 1'b1;
                pending_slots.push_back(r);
            end
            else
            begin
                age = it.now - sweep_at;
                if (sweep_at != 0 && age < resend_gap)
                    return;
                sweep_at = it.now;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (!live[i])
                        continue;
                    age = it.now - stamp[i];
                    if (age > max_age)
                    begin
                        live[i] = 1'b0;
                        continue;
                    end
                    r.kind    = KIND_TICK;
                    r.slot    = i[SLOT_W-1:0];
                    r.matched = 1'b0;
                    r.last    = 1'b0;
                    sweep_q.push_back(r);
                end
                if (sweep_q.size() > 0)
                    sweep_q[sweep_q.size()-1].last = 1'b1;
                foreach (sweep_q[i])
                    pending_slots.push_back(sweep_q[i]);
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(slot_result_t got);
            slot_result_t want;
            if (pending_slots.size() == 0)
            begin
                $display("%0t: result with nothing expected: expected none, actual %p",
                         $time, got);
                errors++;
                return;
            end
            want = pending_slots.pop_front();
            compare_field("result_kind", want.kind, got.kind);
            compare_field("slot", want.slot, got.slot);
            compare_field("matched_existing", want.matched, got.matched);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_CACHE_ENABLE;
    logic [CFG_W-1:0]     cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 kind        = KIND_STORE;
    logic [TIME_W-1:0]    now_tick    = '0;
    logic                 key_present = 1'b0;
    logic [WORD_W-1:0]    key_word0   = '0;
    logic [WORD_W-1:0]    key_word1   = '0;
    logic [WORD_W-1:0]    key_word2   = '0;
    logic [WORD_W-1:0]    key_word3   = '0;
    logic                 out_stall   = 1'b0;
    wire logic            cfg_ready;
    wire logic            in_stall;
    wire logic            out_valid;
    wire logic            result_kind;
    wire logic [SLOT_W-1:0] slot;
    wire logic            matched_existing;
    wire logic            last;

    slot_cache_scoreboard   sb = new();
    int unsigned            idle_pct = 0;
    int unsigned            stall_pct = 0;
    logic                   hold_req = 1'b0;
    int unsigned            quiet_cycles = 0;
    logic [TIME_W-1:0]      cur_time = '0;
    logic [3:0][WORD_W-1:0] key_pool[POOL_SIZE];

    lobby_slot_cache_with_expiry_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .now_tick         (now_tick),
        .key_present      (key_present),
        .key_word0        (key_word0),
        .key_word1        (key_word1),
        .key_word2        (key_word2),
        .key_word3        (key_word3),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .slot             (slot),
        .matched_existing (matched_existing),
        .last             (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin : monitor
        cache_item_t  seen;
        slot_result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index_t'(cfg_index), cfg_data);
            if (in_valid && !in_stall)
            begin
                seen.kind        = kind;
                seen.now         = now_tick;
                seen.key_present = key_present;
                seen.key         = {key_word3, key_word2, key_word1, key_word0};
                sb.note_item(seen);
            end
            if (out_valid && !out_stall)
            begin
                got.kind    = result_kind;
                got.slot    = slot;
                got.matched = matched_existing;
                got.last    = last;
                sb.check_result(got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && !in_stall)
            || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side: random stalls plus a long hold-off on request
    initial
    begin : receiver
        logic        hold_seen;
        int unsigned hold_left;
        hold_seen = 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic cache_item_t store_item(logic [TIME_W-1:0] t, logic has_key,
                                               logic [3:0][WORD_W-1:0] k);
        cache_item_t it;
        it.kind        = KIND_STORE;
        it.now         = t;
        it.key_present = has_key;
        it.key         = k;
        return it;
    endfunction

    function automatic cache_item_t tick_item(logic [TIME_W-1:0] t);
        cache_item_t it;
        it.kind        = KIND_TICK;
        it.now         = t;
        it.key_present = 1'($urandom_range(1));
        for (int w = 0; w < 4; w++)
            it.key[w] = {$urandom, $urandom};
        return it;
    endfunction

    // mostly advancing time and pooled keys, with some noise
    function automatic cache_item_t random_item(int unsigned step_max);
        cache_item_t it;
        int unsigned pick;
        cur_time += $urandom_range(step_max);
        it.kind        = ($urandom_range(99) < 20) ? KIND_TICK : KIND_STORE;
        it.now         = cur_time;
        it.key_present = ($urandom_range(99) < 85);
        pick = $urandom_range(99);
        if (pick < 8)
            it.now = TIME_W'({$urandom, $urandom});
        else if (pick < 10)
            it.now = '0;
        if ($urandom_range(99) < 70)
            it.key = key_pool[$urandom_range(POOL_SIZE-1)];
        else
            for (int w = 0; w < 4; w++)
                it.key[w] = {$urandom, $urandom};
        return it;
    endfunction

    task automatic send_item(cache_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= it.kind;
        now_tick    <= it.now;
        key_present <= it.key_present;
        key_word0   <= it.key[0];
        key_word1   <= it.key[1];
        key_word2   <= it.key[2];
        key_word3   <= it.key[3];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        // items without results may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_reg(cfg_index_t idx, logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(logic en, logic [CFG_W-1:0] gap, logic [CFG_W-1:0] age);
        program_reg(CFG_CACHE_ENABLE, CFG_W'(en));
        program_reg(CFG_RESEND_INTERVAL, gap);
        program_reg(CFG_EXPIRY_AGE, age);
    endtask

    task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned step_max,
                             int unsigned count);
        idle_pct = idle;
        stall_pct <= stall;
        repeat (count) send_item(random_item(step_max));
    endtask

    initial
    begin : stimulus
        logic [3:0][WORD_W-1:0] ones;
        logic [3:0][WORD_W-1:0] zeros;
        ones  = '1;
        zeros = '0;
        for (int p = 0; p < POOL_SIZE; p++)
            for (int w = 0; w < 4; w++)
                key_pool[p][w] = {$urandom, $urandom};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the table: match, keyless entries, zero and maximal stamps
        send_item(store_item(48'd5, 1'b1, key_pool[0]));
        send_item(store_item(48'd0, 1'b1, key_pool[0]));
        send_item(store_item(48'd200, 1'b0, key_pool[1]));
        send_item(store_item(48'd300, 1'b0, key_pool[1]));
        send_item(store_item(48'd400, 1'b1, key_pool[1]));
        send_item(store_item('1, 1'b1, ones));
        send_item(store_item(48'd500, 1'b1, zeros));
        send_item(store_item(48'd600, 1'b1, key_pool[4]));
        send_item(store_item(48'd700, 1'b1, key_pool[5]));
        send_item(store_item(48'd800, 1'b1, key_pool[6]));
        // first sweep, one inside the interval, one exactly at its end
        send_item(tick_item(48'd1000));
        send_item(tick_item(48'd2000));
        send_item(tick_item(48'd1000 + 48'd57600000));
        quiesce();

        set_config(1'b1, '0, '0);
        send_item(store_item(48'd900, 1'b1, key_pool[0]));
        send_item(tick_item(48'd900));
        // sweep at time zero expires everything and counts as never swept
        send_item(tick_item(48'd0));
        quiesce();

        set_config(1'b1, '1, '1);
        send_item(store_item(48'd10, 1'b1, key_pool[1]));
        send_item(tick_item(48'd20));
        send_item(tick_item(48'd30));
        quiesce();

        program_reg(CFG_CACHE_ENABLE, '0);
        send_item(store_item(48'd40, 1'b1, key_pool[2]));
        send_item(tick_item(48'd50));
        quiesce();

        set_config(1'b1, 32'd1000, 32'd8000);
        cur_time = 48'd100;
        run_phase(0, 0, 300, RANDOM_PER_PHASE);
        quiesce();

        // time runs close to the top of its range in this phase
        set_config(1'b1, '0, 32'd2000);
        cur_time = 48'hFFFF_FFFF_0000;
        run_phase(70, 0, 500, RANDOM_PER_PHASE);
        quiesce();

        set_config(1'b1, $urandom_range(100, 5000), $urandom_range(1000, 20000));
        run_phase(0, 70, 800, RANDOM_PER_PHASE);
        quiesce();

        set_config(1'b1, RST_RESEND_INTERVAL, RST_EXPIRY_AGE);
        run_phase(35, 35, 20000000, RANDOM_PER_PHASE);
        quiesce();

        program_reg(CFG_CACHE_ENABLE, '0);
        run_phase(0, 0, 1000, 10);
        quiesce();

        // long receiver hold-off while the sender keeps offering items
        set_config(1'b1, '0, '1);
        hold_req <= ~hold_req;
        run_phase(0, 0, 1000, RANDOM_PER_PHASE);
        quiesce();

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// ===== lobby_slot_cache_with_expiry_top.f =====
+incdir+sv
sv/lsce_pkg.sv
sv/lsce_ram.sv
sv/lsce_ctrl.sv
sv/lobby_slot_cache_with_expiry_top.sv
bench/tb_lobby_slot_cache_with_expiry_top.sv
